/* rtl/actb_pkg.sv */
// Package: widths, constants and CORDIC angle table for the tilt blend block.
package actb_pkg;

  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_STEPS    = 16;
  localparam int ZFRAC           = 24;
  localparam int TABLE_LEN       = 24;
  localparam int NSTEPS = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

  // squares sum: 3 * 2^30 fits in 32 bits
  localparam int SUM_W  = 32;
  localparam int MAG_W  = 16;
  localparam int SQ_W   = 2 * (MAG_W + 1);
  localparam int ROOT_W = MAG_W + 1;
  // bit position or step index handed to each cell
  localparam int RB_W   = 5;
  // CORDIC datapath: |value| <= ~1.65 * 2^17 * 2^24
  localparam int CX_W   = 44;
  localparam int Z_W    = 32;
  localparam int W_W    = 25;
  localparam int WONE   = 1 << 24;

  localparam int AF_W   = 16;
  localparam int BL_W   = 17;

  typedef logic signed [CX_W-1:0] cx_t;
  typedef logic signed [Z_W-1:0]  z_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic z_t atan_tab(input int i);
    z_t t;
    case (i)
      0:  t = 32'sd754974720;
      1:  t = 32'sd445687602;
      2:  t = 32'sd235489088;
      3:  t = 32'sd119537938;
      4:  t = 32'sd60000934;
      5:  t = 32'sd30029717;
      6:  t = 32'sd15018523;
      7:  t = 32'sd7509720;
      8:  t = 32'sd3754917;
      9:  t = 32'sd1877466;
      10: t = 32'sd938734;
      11: t = 32'sd469367;
      12: t = 32'sd234684;
      13: t = 32'sd117342;
      14: t = 32'sd58671;
      15: t = 32'sd29335;
      16: t = 32'sd14668;
      17: t = 32'sd7334;
      18: t = 32'sd3667;
      19: t = 32'sd1833;
      20: t = 32'sd917;
      21: t = 32'sd458;
      22: t = 32'sd229;
      23: t = 32'sd115;
      default: t = '0;
    endcase
    return t;
  endfunction

  // item context carried alongside the pipeline
  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [16:0] gp;
    logic signed [16:0] gr;
    logic [W_W-1:0]     w;
  } ctx_t;

endpackage

/* rtl/actb_if.sv */
// Interfaces: valid/ready channels for input samples and results.
interface actb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [16:0] gyro_pitch;
  logic signed [16:0] gyro_roll;
  modport source (output valid, acc_x, acc_y, acc_z, gyro_pitch, gyro_roll, input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, gyro_pitch, gyro_roll, output ready);
endinterface

interface actb_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pitch_from_acc;
  logic signed [15:0] roll_from_acc;
  logic signed [16:0] pitch_blended;
  logic signed [16:0] roll_blended;
  logic               zero_vector;
  modport source (output valid, pitch_from_acc, roll_from_acc, pitch_blended,
                  roll_blended, zero_vector, input ready);
  modport sink   (input valid, pitch_from_acc, roll_from_acc, pitch_blended,
                  roll_blended, zero_vector, output ready);
endinterface

/* rtl/actb_sqrt_cell.sv */
// Sqrt cell: one restoring root digit per stage.
module actb_sqrt_cell
  import actb_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RB_W-1:0]   bit_idx,
  input  logic [SQ_W-1:0]   rem_in,
  input  logic [ROOT_W-1:0] root_in,
  output logic [SQ_W-1:0]   rem_r,
  output logic [ROOT_W-1:0] root_r
);
  logic [SQ_W-1:0]   trial;
  logic [ROOT_W-1:0] root_nxt;
  logic [SQ_W-1:0]   rem_nxt;

  // try setting this root bit: rem >= (2*root + 2^bit) * 2^bit
  always_comb begin
    trial    = (SQ_W'(root_in) << (bit_idx + RB_W'(1))) + (SQ_W'(1) << {bit_idx, 1'b0});
    rem_nxt  = rem_in;
    root_nxt = root_in;
    if (rem_in >= trial) begin
      rem_nxt  = rem_in - trial;
      root_nxt = root_in | (ROOT_W'(1) << bit_idx);
    end
  end

  // advance when the pipe moves
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end
endmodule

/* rtl/actb_cordic_cell.sv */
// CORDIC cell: one vectoring micro-rotation for two lanes (pitch and roll).
module actb_cordic_cell
  import actb_pkg::*;
(
  input  logic            clk,
  input  logic            en,
  input  logic [RB_W-1:0] step,
  input  cx_t             xp_in, yp_in, xr_in, yr_in,
  input  z_t              zp_in, zr_in,
  output cx_t             xp_r, yp_r, xr_r, yr_r,
  output z_t              zp_r, zr_r
);
  cx_t xp_nxt, yp_nxt, xr_nxt, yr_nxt;
  z_t  zp_nxt, zr_nxt;
  z_t  a;

  // rotate toward the x axis; arithmetic shifts floor
  always_comb begin
    a = atan_tab(int'(step));
    if (!yp_in[CX_W-1]) begin
      xp_nxt = xp_in + (yp_in >>> step);
      yp_nxt = yp_in - (xp_in >>> step);
      zp_nxt = zp_in + a;
    end else begin
      xp_nxt = xp_in - (yp_in >>> step);
      yp_nxt = yp_in + (xp_in >>> step);
      zp_nxt = zp_in - a;
    end
    if (!yr_in[CX_W-1]) begin
      xr_nxt = xr_in + (yr_in >>> step);
      yr_nxt = yr_in - (xr_in >>> step);
      zr_nxt = zr_in + a;
    end else begin
      xr_nxt = xr_in - (yr_in >>> step);
      yr_nxt = yr_in + (xr_in >>> step);
      zr_nxt = zr_in - a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r <= xp_nxt; yp_r <= yp_nxt; zp_r <= zp_nxt;
      xr_r <= xr_nxt; yr_r <= yr_nxt; zr_r <= zr_nxt;
    end
  end
endmodule

/* rtl/accel_tilt_complementary_blend_top.sv */
// Path: magnitude roots, m*m - t*t, cosine roots, CORDIC, round, multiply, sum.
// Throughput: one item per cycle; a chain of root cells, then CORDIC cells.
// The whole chain advances when the output stage is free or being taken,
// so in.ready falls only while a result is stalled at the output.
// Reset: synchronous active-low rst_n clears all valid bits and sets
// acc_weight to 6711; payload registers are not reset.
module accel_tilt_complementary_blend_top
  import actb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [W_W-1:0]   cfg_wdata,
  actb_in_if.sink          in_ch,
  actb_out_if.source       out_ch
);
  localparam int S1 = ROOT_W;          // magnitude root stages
  localparam int S2 = ROOT_W;          // cosine root stages (two lanes)
  localparam int LAT = S1 + 1 + S2 + NSTEPS + 3;

  typedef struct packed {
    ctx_t c;
    logic zero;
  } k_ctx_t;

  logic [W_W-1:0] acc_weight_r;
  logic [LAT-1:0] vld_r;
  logic           en;

  // advance when the last stage is empty or being taken
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_weight_r <= W_W'(6711);
      vld_r        <= '0;
    end else begin
      if (cfg_we) acc_weight_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // ---- magnitude root chain ----
  logic [SQ_W-1:0]   m_rem  [S1+1];
  logic [ROOT_W-1:0] m_root [S1+1];
  ctx_t              m_x0;
  ctx_t              m_x_r  [S1];
  logic [SUM_W-1:0]  s_in;

  // form the exact sum of squares and the item context
  always_comb begin
    s_in = SUM_W'(unsigned'(32'(in_ch.acc_x) * 32'(in_ch.acc_x)))
         + SUM_W'(unsigned'(32'(in_ch.acc_y) * 32'(in_ch.acc_y)))
         + SUM_W'(unsigned'(32'(in_ch.acc_z) * 32'(in_ch.acc_z)));
    m_x0.ax = in_ch.acc_x;
    m_x0.ay = in_ch.acc_y;
    m_x0.gp = in_ch.gyro_pitch;
    m_x0.gr = in_ch.gyro_roll;
    m_x0.w  = acc_weight_r;
  end

  assign m_rem[0]  = SQ_W'(s_in);
  assign m_root[0] = '0;

  for (genvar g = 0; g < S1; g++) begin : g_mroot
    actb_sqrt_cell u_cell (
      .clk, .en, .bit_idx(RB_W'(S1 - 1 - g)),
      .rem_in(m_rem[g]), .root_in(m_root[g]),
      .rem_r(m_rem[g+1]), .root_r(m_root[g+1])
    );
    // carry the item context beside the root
    always_ff @(posedge clk) begin
      if (en) m_x_r[g] <= (g == 0) ? m_x0 : m_x_r[(g == 0) ? 0 : g - 1];
    end
  end

  // ---- form m*m - t*t for both lanes ----
  logic [SQ_W-1:0]   dp_r, dr_r;
  k_ctx_t            k_x_r;
  logic [ROOT_W-1:0] mm;
  logic [15:0]       apy, apx;

  always_comb begin
    mm  = m_root[S1];
    apy = m_x_r[S1-1].ay[15] ? 16'(-m_x_r[S1-1].ay) : 16'(m_x_r[S1-1].ay);
    apx = m_x_r[S1-1].ax[15] ? 16'(-m_x_r[S1-1].ax) : 16'(m_x_r[S1-1].ax);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp_r  <= SQ_W'(mm) * SQ_W'(mm) - SQ_W'(apy) * SQ_W'(apy);
      dr_r  <= SQ_W'(mm) * SQ_W'(mm) - SQ_W'(apx) * SQ_W'(apx);
      k_x_r <= '{c: m_x_r[S1-1], zero: (mm == '0)};
    end
  end

  // ---- cosine root chains, one per lane ----
  logic [SQ_W-1:0]   cp_rem  [S2+1], cr_rem  [S2+1];
  logic [ROOT_W-1:0] cp_root [S2+1], cr_root [S2+1];
  k_ctx_t            c_x_r   [S2];

  assign cp_rem[0]  = dp_r;
  assign cp_root[0] = '0;
  assign cr_rem[0]  = dr_r;
  assign cr_root[0] = '0;

  for (genvar g = 0; g < S2; g++) begin : g_croot
    actb_sqrt_cell u_pitch (
      .clk, .en, .bit_idx(RB_W'(S2 - 1 - g)),
      .rem_in(cp_rem[g]), .root_in(cp_root[g]),
      .rem_r(cp_rem[g+1]), .root_r(cp_root[g+1])
    );
    actb_sqrt_cell u_roll (
      .clk, .en, .bit_idx(RB_W'(S2 - 1 - g)),
      .rem_in(cr_rem[g]), .root_in(cr_root[g]),
      .rem_r(cr_rem[g+1]), .root_r(cr_root[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) c_x_r[g] <= (g == 0) ? k_x_r : c_x_r[(g == 0) ? 0 : g - 1];
    end
  end

  // ---- CORDIC chain ----
  cx_t xp [NSTEPS+1], yp [NSTEPS+1], xr [NSTEPS+1], yr [NSTEPS+1];
  z_t  zp [NSTEPS+1], zr [NSTEPS+1];
  k_ctx_t kx_r [NSTEPS];

  assign xp[0] = cx_t'({cp_root[S2], 24'd0});
  assign yp[0] = cx_t'(c_x_r[S2-1].c.ay) <<< ZFRAC;
  assign xr[0] = cx_t'({cr_root[S2], 24'd0});
  assign yr[0] = cx_t'(c_x_r[S2-1].c.ax) <<< ZFRAC;
  assign zp[0] = '0;
  assign zr[0] = '0;

  for (genvar g = 0; g < NSTEPS; g++) begin : g_cordic
    actb_cordic_cell u_cell (
      .clk, .en, .step(RB_W'(g)),
      .xp_in(xp[g]), .yp_in(yp[g]), .xr_in(xr[g]), .yr_in(yr[g]),
      .zp_in(zp[g]), .zr_in(zr[g]),
      .xp_r(xp[g+1]), .yp_r(yp[g+1]), .xr_r(xr[g+1]), .yr_r(yr[g+1]),
      .zp_r(zp[g+1]), .zr_r(zr[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) kx_r[g] <= (g == 0) ? c_x_r[S2-1] : kx_r[(g == 0) ? 0 : g - 1];
    end
  end

  // ---- round, clamp, negate roll; then blend products ----
  localparam int RS = ZFRAC - ANGLE_FRAC_BITS;
  localparam int LIM = 90 << ANGLE_FRAC_BITS;

  function automatic logic signed [AF_W-1:0] rnd_clamp(input z_t z);
    logic [Z_W-1:0] mag;
    logic [Z_W-1:0] q;
    logic signed [Z_W:0] r;
    mag = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
    q   = (mag + Z_W'(1 << (RS - 1))) >> RS;
    if (q > Z_W'(LIM)) q = Z_W'(LIM);
    r = z[Z_W-1] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return AF_W'(r);
  endfunction

  logic signed [AF_W-1:0] pa_r, ra_r;
  k_ctx_t a_x_r;
  logic [W_W-1:0] wc;

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r  <= kx_r[NSTEPS-1].zero ? '0 : rnd_clamp(zp[NSTEPS]);
      ra_r  <= kx_r[NSTEPS-1].zero ? '0 : AF_W'(-rnd_clamp(zr[NSTEPS]));
      a_x_r <= kx_r[NSTEPS-1];
    end
  end

  // multiply stage: gyro*(1-w), acc*w
  localparam int P_W = 44;
  logic signed [P_W-1:0] gp_p_r, ap_p_r, gr_p_r, ar_p_r;
  logic signed [P_W-1:0] wg_s, wa_s;
  logic signed [AF_W-1:0] pa2_r, ra2_r;
  logic zero2_r;

  // clip the weight at one and widen both weights
  always_comb begin
    wc   = (a_x_r.c.w > W_W'(WONE)) ? W_W'(WONE) : a_x_r.c.w;
    wa_s = P_W'(wc);
    wg_s = P_W'(W_W'(WONE) - wc);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gp_p_r  <= P_W'(a_x_r.c.gp) * wg_s;
      gr_p_r  <= P_W'(a_x_r.c.gr) * wg_s;
      ap_p_r  <= P_W'(pa_r) * wa_s;
      ar_p_r  <= P_W'(ra_r) * wa_s;
      pa2_r   <= pa_r;
      ra2_r   <= ra_r;
      zero2_r <= a_x_r.zero;
    end
  end

  function automatic logic signed [BL_W-1:0] rnd24(input logic signed [P_W-1:0] v);
    logic [P_W-1:0] mag;
    logic [P_W-1:0] q;
    mag = v[P_W-1] ? P_W'(-v) : P_W'(v);
    q   = (mag + P_W'(1 << 23)) >> 24;
    return v[P_W-1] ? BL_W'(-q) : BL_W'(q);
  endfunction

  // sum, round and drive output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.pitch_blended  <= rnd24(gp_p_r + ap_p_r);
      out_ch.roll_blended   <= rnd24(gr_p_r + ar_p_r);
      out_ch.pitch_from_acc <= pa2_r;
      out_ch.roll_from_acc  <= ra2_r;
      out_ch.zero_vector    <= zero2_r;
    end
  end

  assign out_ch.valid = vld_r[LAT-1];
endmodule

/* rtl/actb_checker.sv */
// Checker: port-level properties of the tilt blend block, bound to the top level.
module actb_checker
  import actb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic zero_vector,
  input logic signed [15:0] pitch_from_acc,
  input logic signed [15:0] roll_from_acc
);
  // input side stalls only on a held result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready)) else $error("ready low without output stall");
  // stalled result stays valid and keeps its pitch
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(pitch_from_acc))
    else $error("stalled result changed");
  // zero vector forces zero angles
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && zero_vector) |-> (pitch_from_acc == 0 && roll_from_acc == 0))
    else $error("zero vector with nonzero angle");
  // pitch angle within +-90 degrees
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pitch_from_acc <= 16'sd23040 && pitch_from_acc >= -16'sd23040))
    else $error("pitch out of range");
endmodule

bind accel_tilt_complementary_blend_top actb_checker u_actb_checker (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .zero_vector(out_ch.zero_vector),
  .pitch_from_acc(out_ch.pitch_from_acc),
  .roll_from_acc(out_ch.roll_from_acc)
);

/* verif/tb_accel_tilt_complementary_blend_top.sv */
// Testbench: tilt blend block checked against an in-bench predictor of tilt and blend.
module tb_accel_tilt_complementary_blend_top;
  import actb_pkg::*;

  localparam int LATENCY = 54;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [W_W-1:0] cfg_wdata;

  actb_in_if  in_ch ();
  actb_out_if out_ch ();

  accel_tilt_complementary_blend_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  typedef struct packed {
    logic signed [15:0] pitch_acc;
    logic signed [15:0] roll_acc;
    logic signed [16:0] pitch_bl;
    logic signed [16:0] roll_bl;
    logic               zero;
  } tilt_t;

  tilt_t tilt_q[$];
  logic [W_W-1:0] weight;
  int errors;
  int idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // round to nearest, ties away from zero
  function automatic longint round_away(longint v, int s);
    longint h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  // asin(t/m) in degrees * 256 by CORDIC vectoring
  function automatic longint tilt_deg(longint t, longint m);
    longint tt, xc, yc, z, dx, dy, r, lim;
    tt = (t < 0) ? -t : t;
    xc = longint'(root_floor(m * m - tt * tt)) <<< ZFRAC;
    yc = t <<< ZFRAC;
    z = 0;
    for (int i = 0; i < NSTEPS; i++) begin
      dx = yc >>> i;
      dy = xc >>> i;
      if (yc >= 0) begin
        xc += dx; yc -= dy; z += longint'(atan_tab(i));
      end else begin
        xc -= dx; yc += dy; z -= longint'(atan_tab(i));
      end
    end
    r = round_away(z, ZFRAC - ANGLE_FRAC_BITS);
    lim = 90 <<< ANGLE_FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic tilt_t predict_tilt(logic signed [15:0] ax, logic signed [15:0] ay,
                                         logic signed [15:0] az, logic signed [16:0] gp,
                                         logic signed [16:0] gr);
    tilt_t e;
    longint x, y, zz, m, pa, ra, w;
    x = ax; y = ay; zz = az;
    w = (weight > WONE) ? WONE : weight;
    m = longint'(root_floor(longint'(x * x + y * y + zz * zz)));
    pa = 0; ra = 0;
    if (m != 0) begin
      pa = tilt_deg(y, m);
      ra = -tilt_deg(x, m);
    end
    e.pitch_acc = pa[15:0];
    e.roll_acc  = ra[15:0];
    e.pitch_bl  = 17'(round_away(longint'(gp) * (WONE - w) + pa * w, 24));
    e.roll_bl   = 17'(round_away(longint'(gr) * (WONE - w) + ra * w, 24));
    e.zero      = (m == 0);
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // send one sample, hold until accepted
  task automatic send_sample(int x, int y, int z, int gp, int gr);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) @(negedge clk);
    in_ch.valid      = 1'b1;
    in_ch.acc_x      = 16'(x);
    in_ch.acc_y      = 16'(y);
    in_ch.acc_z      = 16'(z);
    in_ch.gyro_pitch = 17'(gp);
    in_ch.gyro_roll  = 17'(gr);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tilt_q.push_back(predict_tilt(16'(x), 16'(y), 16'(z), 17'(gp), 17'(gr)));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // drain, settle, then write the weight
  task automatic set_weight(logic [W_W-1:0] w);
    while (tilt_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    weight = w;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // check each result against the oldest expectation
  always @(posedge clk) begin
    tilt_t g, e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = {out_ch.pitch_from_acc, out_ch.roll_from_acc, out_ch.pitch_blended,
           out_ch.roll_blended, out_ch.zero_vector};
      if (tilt_q.size() == 0) begin
        report("unexpected result", 1, 0);
      end else begin
        e = tilt_q.pop_front();
        if (g.pitch_acc !== e.pitch_acc) report("pitch_from_acc", g.pitch_acc, e.pitch_acc);
        if (g.roll_acc !== e.roll_acc) report("roll_from_acc", g.roll_acc, e.roll_acc);
        if (g.pitch_bl !== e.pitch_bl) report("pitch_blended", g.pitch_bl, e.pitch_bl);
        if (g.roll_bl !== e.roll_bl) report("roll_blended", g.roll_bl, e.roll_bl);
        if (g.zero !== e.zero) report("zero_vector", g.zero, e.zero);
      end
    end
  end

  // stall the result side
  always @(negedge clk) begin
    out_ch.ready <= !(idle_pct > 0 && $urandom_range(99) < idle_pct);
  end

  task automatic test_extremes();
    send_sample(0, 0, 0, 46080, -46080);
    send_sample(0, 0, 0, -65536, 65535);
    send_sample(-32768, -32768, -32768, 0, 0);
    send_sample(32767, 32767, 32767, 46080, 46080);
    send_sample(32767, 0, 0, -46080, 46080);
    send_sample(-32768, 0, 0, 0, 0);
    send_sample(0, 32767, 0, 100, -100);
    send_sample(0, -32768, 0, 65535, -65536);
    send_sample(0, 0, -32768, 1, -1);
    send_sample(1, 0, 0, 0, 0);
    send_sample(0, -1, 0, 0, 0);
    send_sample(1, 1, 1, 0, 0);
    send_sample(3, 4, 0, 12, 34);
  endtask

  task automatic random_samples(int n);
    int x, y, z;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: begin x = $urandom_range(4) - 2; y = $urandom_range(4) - 2;
                 z = $urandom_range(4) - 2; end
        1: begin x = $urandom_range(1) ? -32768 : 32767; y = $urandom_range(65535) - 32768;
                 z = 0; end
        default: begin x = $urandom_range(65535) - 32768; y = $urandom_range(65535) - 32768;
                 z = $urandom_range(65535) - 32768; end
      endcase
      if ($urandom_range(19) == 0)
        send_sample(x, y, z, $urandom_range(131071) - 65536, $urandom_range(131071) - 65536);
      else
        send_sample(x, y, z, $urandom_range(92160) - 46080, $urandom_range(92160) - 46080);
    end
  endtask

  task automatic test_weights();
    set_weight(25'd0);
    test_extremes();
    set_weight(25'd16777216);
    test_extremes();
    set_weight(25'h1FFFFFF);
    test_extremes();
    set_weight(25'd8388608);
    random_samples(40);
  endtask

  task automatic test_random();
    idle_pct = 0;
    random_samples(200);
    idle_pct = 9;
    set_weight(25'($urandom_range(16777216)));
    random_samples(300);
    set_weight(25'd6711);
    random_samples(300);
    set_weight(25'($urandom_range(33554431)));
    random_samples(150);
  endtask

  initial begin
    errors = 0;
    idle_pct = 9;
    weight = 25'd6711;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.acc_x = '0;
    in_ch.acc_y = '0;
    in_ch.acc_z = '0;
    in_ch.gyro_pitch = '0;
    in_ch.gyro_roll = '0;
    out_ch.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_weights();
    test_random();
    while (tilt_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (errors == 0)
      $display("tb_accel_tilt_complementary_blend_top OK");
    else
      $display("tb_accel_tilt_complementary_blend_top NOT OK");
    $finish;
  end

  // end a hung run
  initial begin
    #400000;
    $display("tb_accel_tilt_complementary_blend_top NOT OK");
    $finish;
  end

endmodule
